/* rtl/cdwq_pkg.sv */
// ----------------------------------------------------------------------------
// cdwq_pkg
// Shared types, codes and defaults for the coalescing dirty work queue.
// ----------------------------------------------------------------------------
package cdwq_pkg;

  localparam int N_ENTRIES_DEF = 1024;
  localparam int MAX_DRAIN_DEF = 64;
  localparam int NS_PER_US     = 1000;

  localparam logic [2:0] CMD_MARK   = 3'd0;
  localparam logic [2:0] CMD_DRAIN  = 3'd1;
  localparam logic [2:0] CMD_FINISH = 3'd2;
  localparam logic [2:0] CMD_AGE    = 3'd3;
  localparam logic [2:0] CMD_CLEAR  = 3'd4;

  localparam logic [3:0] ST_QUEUED    = 4'd0;
  localparam logic [3:0] ST_COALESCED = 4'd1;
  localparam logic [3:0] ST_DROPPED   = 4'd2;
  localparam logic [3:0] ST_OOR       = 4'd3;
  localparam logic [3:0] ST_TASK      = 4'd4;
  localparam logic [3:0] ST_EMPTY     = 4'd5;
  localparam logic [3:0] ST_RECHK_NOW = 4'd6;
  localparam logic [3:0] ST_REQUEUED  = 4'd7;
  localparam logic [3:0] ST_RELEASED  = 4'd8;
  localparam logic [3:0] ST_AGE       = 4'd9;
  localparam logic [3:0] ST_CLEARED   = 4'd10;

  typedef enum logic [1:0] {
    E_IDLE    = 2'd0,
    E_QUEUED  = 2'd1,
    E_PROC    = 2'd2,
    E_RECHECK = 2'd3
  } ent_state_t;

  typedef struct packed {
    ent_state_t  state;
    logic [62:0] event_time;
    logic [62:0] queued_time;
  } entry_t;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [15:0] entry_index;
    logic [62:0] event_time;
    logic [62:0] now_time;
    logic [6:0]  max_count;
    logic        allow_recheck;
  } in_req_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [15:0] task_entry;
    logic [62:0] task_event_time;
    logic [62:0] task_queued_time;
    logic [53:0] age_us;
    logic [16:0] queue_depth;
    logic        last;
  } out_res_t;

endpackage

/* rtl/cdwq_ram.sv */
// ----------------------------------------------------------------------------
// cdwq_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module cdwq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/coalescing_dirty_work_queue.sv */
// ----------------------------------------------------------------------------
// coalescing_dirty_work_queue
// Deduplicating ring work queue with coalescing marks and recheck on finish.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one request per command (mark, drain, finish, age, clear).
//   out_* : results; each request gives one, a drain up to max_count, and the
//           final result of a request has last set. Unknown commands give none.
//   One request is worked on at a time; in_stall is high while it runs.
//   Steps from one acceptance to the next:
//   Mark and finish: accept and entry RAM read, write back, output load.
//   Drain: accept, then per popped task ring read, entry read, write back,
//   output load; an empty drain has only the output load. Age query: the
//   divide by 1000 runs at 16 quotient bits a cycle and is skipped if age is
//   zero. Clear: a sweep through the entry RAM, one entry a cycle, with
//   in_stall high, then the cleared result. Reset runs the same sweep without
//   a result.
//   While out_stall is high a valid result waits in the output register and
//   work halts in S_OUT, before the next result is loaded, until it is taken.
// ----------------------------------------------------------------------------
module coalescing_dirty_work_queue
  import cdwq_pkg::*;
#(
  parameter int N_ENTRIES = N_ENTRIES_DEF,
  parameter int MAX_DRAIN = MAX_DRAIN_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_req_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output out_res_t out_data
);

  localparam int IW = $clog2(N_ENTRIES);
  localparam int CW = $clog2(N_ENTRIES + 1);
  // floor(v / 1000) == (v * RECIP_US) >> 36 for every v below 2**26
  localparam logic [26:0] RECIP_US = 27'd68719477;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_MOD, S_AGE_ENT, S_AGE_CALC, S_DIV,
    D_RING, D_ENT, D_OUT, S_OUT
  } fsm_t;

  fsm_t        state_r, state_nxt;
  in_req_t     req_r, req_nxt;
  logic [IW-1:0] head_r, head_nxt, tail_r, tail_nxt, clr_idx_r, clr_idx_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt, fin_depth_r, fin_depth_nxt;
  logic [6:0]  left_r, left_nxt;
  logic        more_r, more_nxt, clr_reply_r, clr_reply_nxt;
  out_res_t    res_r, res_nxt, out_r, out_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [63:0] div_r, div_nxt, quo_r, quo_nxt;
  logic [9:0]  rem_r, rem_nxt;
  logic [1:0]  dcnt_r, dcnt_nxt;

  logic          ent_we, ent_re, ring_we, ring_re;
  logic [IW-1:0] ent_waddr, ent_raddr, ring_waddr;
  entry_t        ent_wdata, ent_q;
  logic [IW-1:0] ring_wdata, ring_q;

  logic [16:0] mc, nfull, n_pop;
  logic        oor;
  logic [25:0] dv, dsub;
  logic [52:0] dprod;
  logic [15:0] dq;
  entry_t      e_cur;
  logic [IW-1:0] idx_e;

  cdwq_ram #(.WIDTH($bits(entry_t)), .DEPTH(N_ENTRIES)) u_ent (
    .clk(clk), .we(ent_we), .waddr(ent_waddr), .wdata(ent_wdata),
    .re(ent_re), .raddr(ent_raddr), .rdata(ent_q)
  );

  cdwq_ram #(.WIDTH(IW), .DEPTH(N_ENTRIES)) u_ring (
    .clk(clk), .we(ring_we), .waddr(ring_waddr), .wdata(ring_wdata),
    .re(ring_re), .raddr(head_r), .rdata(ring_q)
  );

  function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] p);
    wrap_inc = (p == IW'(N_ENTRIES - 1)) ? '0 : p + 1'b1;
  endfunction

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign ring_waddr = tail_r;
  assign idx_e = req_r.entry_index[IW-1:0];
  assign oor = ({1'b0, req_r.entry_index} >= 17'(N_ENTRIES));
  // one 16-bit quotient digit per cycle, remainder carried in rem_r
  assign dv = {rem_r, div_r[63:48]};
  assign dprod = {27'd0, dv} * {26'd0, RECIP_US};
  assign dq = dprod[51:36];
  assign dsub = dv - 26'(dq) * 26'(NS_PER_US);
  assign mc = (in_data.max_count > 7'(MAX_DRAIN)) ? 17'(MAX_DRAIN)
                                                  : 17'(in_data.max_count);
  assign nfull = 17'(cnt_r);
  assign n_pop = (nfull < mc) ? nfull : mc;
  assign e_cur = ent_q;

  always_comb begin
    state_nxt = state_r;
    req_nxt = req_r;
    head_nxt = head_r;
    tail_nxt = tail_r;
    cnt_nxt = cnt_r;
    fin_depth_nxt = fin_depth_r;
    left_nxt = left_r;
    more_nxt = more_r;
    clr_idx_nxt = clr_idx_r;
    clr_reply_nxt = clr_reply_r;
    res_nxt = res_r;
    out_nxt = out_r;
    out_valid_nxt = out_valid_r & out_stall;
    div_nxt = div_r;
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    dcnt_nxt = dcnt_r;
    ent_we = 1'b0;
    ent_re = 1'b0;
    ent_waddr = idx_e;
    ent_raddr = in_data.entry_index[IW-1:0];
    ent_wdata = e_cur;
    ring_we = 1'b0;
    ring_re = 1'b0;
    ring_wdata = idx_e;

    unique case (state_r)
      S_CLEAR: begin
        ent_we = 1'b1;
        ent_waddr = clr_idx_r;
        ent_wdata = '{state: E_IDLE, event_time: '0, queued_time: '0};
        clr_idx_nxt = wrap_inc(clr_idx_r);
        if (clr_idx_r == IW'(N_ENTRIES - 1)) begin
          if (clr_reply_r) begin
            res_nxt = '0;
            res_nxt.status = ST_CLEARED;
            res_nxt.last = 1'b1;
            more_nxt = 1'b0;
            state_nxt = S_OUT;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          req_nxt = in_data;
          ent_re = 1'b1;
          ring_re = (in_data.cmd == CMD_AGE);
          res_nxt = '0;
          res_nxt.last = 1'b1;
          more_nxt = 1'b0;
          unique case (in_data.cmd)
            CMD_MARK, CMD_FINISH: state_nxt = S_MOD;
            CMD_AGE: state_nxt = S_AGE_ENT;
            CMD_DRAIN: begin
              if (n_pop == '0) begin
                res_nxt.status = ST_EMPTY;
                res_nxt.queue_depth = 17'(cnt_r);
                state_nxt = S_OUT;
              end else begin
                left_nxt = 7'(n_pop);
                fin_depth_nxt = CW'(nfull - n_pop);
                state_nxt = D_RING;
              end
            end
            CMD_CLEAR: begin
              head_nxt = '0;
              tail_nxt = '0;
              cnt_nxt = '0;
              clr_idx_nxt = '0;
              clr_reply_nxt = 1'b1;
              state_nxt = S_CLEAR;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_MOD: begin
        res_nxt.queue_depth = 17'(cnt_r);
        state_nxt = S_OUT;
        if (oor) begin
          res_nxt.status = ST_OOR;
        end else if (req_r.cmd == CMD_MARK) begin
          ent_we = 1'b1;
          if (e_cur.state != E_IDLE) begin
            if (req_r.event_time > e_cur.event_time) begin
              ent_wdata.event_time = req_r.event_time;
            end
            if (e_cur.state == E_PROC) begin
              ent_wdata.state = E_RECHECK;
            end
            res_nxt.status = ST_COALESCED;
          end else if (cnt_r < CW'(N_ENTRIES)) begin
            ring_we = 1'b1;
            tail_nxt = wrap_inc(tail_r);
            cnt_nxt = cnt_r + 1'b1;
            res_nxt.queue_depth = 17'(cnt_r) + 17'd1;
            ent_wdata = '{state: E_QUEUED, event_time: req_r.event_time,
                          queued_time: req_r.now_time};
            res_nxt.status = ST_QUEUED;
          end else begin
            ent_wdata = '{state: E_IDLE, event_time: '0, queued_time: '0};
            res_nxt.status = ST_DROPPED;
          end
        end else begin
          ent_we = 1'b1;
          if (e_cur.state == E_RECHECK) begin
            if (req_r.allow_recheck) begin
              ent_wdata.state = E_PROC;
              ent_wdata.queued_time = req_r.now_time;
              res_nxt.status = ST_RECHK_NOW;
              res_nxt.task_entry = req_r.entry_index;
              res_nxt.task_event_time = e_cur.event_time;
              res_nxt.task_queued_time = req_r.now_time;
            end else if (cnt_r < CW'(N_ENTRIES)) begin
              ring_we = 1'b1;
              tail_nxt = wrap_inc(tail_r);
              cnt_nxt = cnt_r + 1'b1;
              res_nxt.queue_depth = 17'(cnt_r) + 17'd1;
              ent_wdata.state = E_QUEUED;
              ent_wdata.queued_time = req_r.now_time;
              res_nxt.status = ST_REQUEUED;
            end else begin
              ent_wdata = '{state: E_IDLE, event_time: '0, queued_time: '0};
              res_nxt.status = ST_DROPPED;
            end
          end else begin
            ent_wdata = '{state: E_IDLE, event_time: '0, queued_time: '0};
            res_nxt.status = ST_RELEASED;
          end
        end
      end
      S_AGE_ENT: begin
        ent_re = 1'b1;
        ent_raddr = ring_q;
        state_nxt = S_AGE_CALC;
      end
      S_AGE_CALC: begin
        res_nxt.status = ST_AGE;
        res_nxt.queue_depth = 17'(cnt_r);
        if (cnt_r != '0 && e_cur.queued_time != '0 &&
            req_r.now_time > e_cur.queued_time) begin
          div_nxt = {1'b0, req_r.now_time - e_cur.queued_time};
          quo_nxt = '0;
          rem_nxt = '0;
          dcnt_nxt = '0;
          state_nxt = S_DIV;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_DIV: begin
        rem_nxt = dsub[9:0];
        quo_nxt = {quo_r[47:0], dq};
        div_nxt = {div_r[47:0], 16'd0};
        dcnt_nxt = dcnt_r + 1'b1;
        if (dcnt_r == 2'd3) begin
          res_nxt.age_us = quo_nxt[53:0];
          state_nxt = S_OUT;
        end
      end
      D_RING: begin
        ring_re = 1'b1;
        head_nxt = wrap_inc(head_r);
        cnt_nxt = cnt_r - 1'b1;
        state_nxt = D_ENT;
      end
      D_ENT: begin
        ent_re = 1'b1;
        ent_raddr = ring_q;
        state_nxt = D_OUT;
      end
      D_OUT: begin
        ent_we = 1'b1;
        ent_waddr = ring_q;
        ent_wdata.state = E_PROC;
        res_nxt = '0;
        res_nxt.status = ST_TASK;
        res_nxt.task_entry = 16'(ring_q);
        res_nxt.task_event_time = e_cur.event_time;
        res_nxt.task_queued_time = e_cur.queued_time;
        res_nxt.queue_depth = 17'(fin_depth_r);
        res_nxt.last = (left_r == 7'd1);
        more_nxt = (left_r != 7'd1);
        left_nxt = left_r - 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_nxt = res_r;
          out_valid_nxt = 1'b1;
          state_nxt = more_r ? D_RING : S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      head_r <= '0;
      tail_r <= '0;
      cnt_r <= '0;
      left_r <= '0;
      more_r <= 1'b0;
      clr_idx_r <= '0;
      clr_reply_r <= 1'b0;
      out_valid_r <= 1'b0;
      dcnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      cnt_r <= cnt_nxt;
      left_r <= left_nxt;
      more_r <= more_nxt;
      clr_idx_r <= clr_idx_nxt;
      clr_reply_r <= clr_reply_nxt;
      out_valid_r <= out_valid_nxt;
      dcnt_r <= dcnt_nxt;
    end
    req_r <= req_nxt;
    fin_depth_r <= fin_depth_nxt;
    res_r <= res_nxt;
    out_r <= out_nxt;
    div_r <= div_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
  end

endmodule
